// ----- design/sdn_isj_pkg.sv -----
`timescale 1ns / 1ps

package sdn_isj_pkg;

    // junction size and field widths
    localparam int NUM_PORTS = 5;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int NODE_W    = 19;
    localparam int FRAC_W    = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = {GAIN_W{1'b1}};

    // internal widths follow from the port count
    localparam int SUM_W  = SAMPLE_W + $clog2(NUM_PORTS + 1);
    localparam int NUM_W  = SAMPLE_W + $clog2(3 * NUM_PORTS + 4);
    localparam int PROD_W = NUM_W + GAIN_W + 1;
    localparam int U_W    = PROD_W - FRAC_W;
    localparam int UP_W   = U_W - 1 + $clog2(NUM_PORTS + 1);
    localparam int NSUM_W = SAMPLE_W + $clog2(NUM_PORTS) + 1;

    // round to nearest, ties up: floor((prod + N*2^15) / (N*2^16))
    localparam logic signed [PROD_W-1:0] ROUND_BIAS =
        PROD_W'(longint'(NUM_PORTS) << (FRAC_W - 1));
    // offset that keeps the dividend non-negative, a multiple of N
    localparam logic [UP_W-1:0] DIV_OFFSET = UP_W'(longint'(NUM_PORTS) << (U_W - 1));
    localparam logic [UP_W:0]   QUOT_BIAS  = (UP_W + 1)'(longint'(1) << (U_W - 1));
    // reciprocal of N scaled by 2^UP_W
    localparam logic [UP_W-1:0] DIV_RECIP  = UP_W'((longint'(1) << UP_W) / NUM_PORTS);
    localparam logic [UP_W-1:0] DIV_N      = UP_W'(NUM_PORTS);

    // pipeline stages inside one lane
    localparam int LANE_STAGES = 5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [LANE_STAGES-1:0] en;
    } t_lane_ctrl;

endpackage

// ----- design/sdn_isj_if.sv -----
`timescale 1ns / 1ps

interface sdn_isj_in_if import sdn_isj_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] source_sample;
    logic signed [SAMPLE_W-1:0] wave_in_0;
    logic signed [SAMPLE_W-1:0] wave_in_1;
    logic signed [SAMPLE_W-1:0] wave_in_2;
    logic signed [SAMPLE_W-1:0] wave_in_3;
    logic signed [SAMPLE_W-1:0] wave_in_4;

    modport source (
        output valid, source_sample, wave_in_0, wave_in_1, wave_in_2, wave_in_3,
               wave_in_4,
        input  ready
    );
    modport sink (
        input  valid, source_sample, wave_in_0, wave_in_1, wave_in_2, wave_in_3,
               wave_in_4,
        output ready
    );
endinterface

interface sdn_isj_out_if import sdn_isj_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] wave_out_0;
    logic signed [SAMPLE_W-1:0] wave_out_1;
    logic signed [SAMPLE_W-1:0] wave_out_2;
    logic signed [SAMPLE_W-1:0] wave_out_3;
    logic signed [SAMPLE_W-1:0] wave_out_4;
    logic signed [NODE_W-1:0]   node_output;

    modport source (
        output valid, wave_out_0, wave_out_1, wave_out_2, wave_out_3, wave_out_4,
               node_output,
        input  ready
    );
    modport sink (
        input  valid, wave_out_0, wave_out_1, wave_out_2, wave_out_3, wave_out_4,
               node_output,
        output ready
    );
endinterface

// ----- design/sdn_isj_lane.sv -----
`timescale 1ns / 1ps

module sdn_isj_lane import sdn_isj_pkg::*; (
    input  logic                       i_clk,
    input  t_lane_ctrl                 i_ctrl,
    input  logic [GAIN_W-1:0]          i_gain,
    input  logic signed [SAMPLE_W-1:0] i_src,
    input  logic signed [SUM_W-1:0]    i_sum,
    input  logic signed [SAMPLE_W-1:0] i_x,
    output logic signed [SAMPLE_W-1:0] o_wave
);

    localparam logic signed [NUM_W-1:0] N_S    = NUM_W'(NUM_PORTS);
    localparam logic signed [UP_W:0]    SAT_HI = (UP_W + 1)'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [UP_W:0]    SAT_LO = -((UP_W + 1)'(1 << (SAMPLE_W - 1)));

    logic signed [NUM_W-1:0]  r_num;
    logic signed [PROD_W-1:0] r_prod;
    logic [UP_W-1:0]          r_up;
    logic [2*UP_W-1:0]        r_rprod;
    logic [UP_W-1:0]          r_quot;
    logic signed [SAMPLE_W-1:0] r_wave;

    logic signed [NUM_W-1:0]  w_two_sum;
    logic signed [NUM_W-1:0]  w_nx;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [GAIN_W:0]   w_gain_s;
    logic signed [PROD_W-1:0] w_t;
    logic signed [U_W-1:0]    w_u;
    logic [UP_W-1:0]          w_up;
    logic [UP_W-1:0]          w_qe;
    logic [UP_W-1:0]          w_rem;
    logic signed [UP_W:0]     w_q;
    logic signed [SAMPLE_W-1:0] w_sat;

    always_comb begin
        // numerator 2*S - N*x - s, exact
        w_two_sum = NUM_W'(i_sum) <<< 1;
        w_nx      = NUM_W'(i_x) * N_S;
        w_num     = w_two_sum - w_nx - NUM_W'(i_src);
        w_gain_s  = {1'b0, i_gain};
        // drop the gain fraction, then bias to a non-negative dividend
        w_t       = r_prod + ROUND_BIAS;
        w_u       = w_t[PROD_W-1:FRAC_W];
        w_up      = UP_W'(w_u) + DIV_OFFSET;
        // quotient estimate is low by at most one
        w_qe      = r_rprod[2*UP_W-1:UP_W];
        w_rem     = r_up - UP_W'(w_qe * DIV_N);
        w_q       = $signed({1'b0, r_quot}) - $signed(QUOT_BIAS);
        if (w_q > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_W-1:0];
        end else if (w_q < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_W-1:0];
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_num <= w_num;
        end
        if (i_ctrl.en[1]) begin
            r_prod <= r_num * w_gain_s;
        end
        if (i_ctrl.en[2]) begin
            r_up    <= w_up;
            r_rprod <= w_up * DIV_RECIP;
        end
        if (i_ctrl.en[3]) begin
            r_quot <= w_qe + UP_W'(w_rem >= DIV_N);
        end
        if (i_ctrl.en[4]) begin
            r_wave <= w_sat;
        end
    end

    assign o_wave = r_wave;

endmodule

// ----- design/sdn_isj_merge.sv -----
`timescale 1ns / 1ps

module sdn_isj_merge import sdn_isj_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_sample i_wave [NUM_PORTS],
    output t_sample o_wave [NUM_PORTS],
    output logic signed [NODE_W-1:0] o_node
);

    localparam logic signed [NSUM_W-1:0] NODE_HI = NSUM_W'((1 << (NODE_W - 1)) - 1);
    localparam logic signed [NSUM_W-1:0] NODE_LO = -(NSUM_W'(1 << (NODE_W - 1)));

    t_sample                   r_wave [NUM_PORTS];
    logic signed [NODE_W-1:0]  r_node;
    logic signed [NSUM_W-1:0]  w_sum;
    logic signed [NODE_W-1:0]  w_node;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NUM_PORTS; k++) begin
            w_sum = w_sum + NSUM_W'(i_wave[k]);
        end
        if (w_sum > NODE_HI) begin
            w_node = NODE_HI[NODE_W-1:0];
        end else if (w_sum < NODE_LO) begin
            w_node = NODE_LO[NODE_W-1:0];
        end else begin
            w_node = w_sum[NODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wave <= i_wave;
            r_node <= w_node;
        end
    end

    assign o_wave = r_wave;
    assign o_node = r_node;

endmodule

// ----- design/sdn_isotropic_scattering_junction_unit.sv -----
`timescale 1ns / 1ps
// isotropic scattering junction for one delay network node
// request channel i_req: one source sample and one incoming wave per connection
// response channel o_rsp: one outgoing wave per connection plus the node output,
// exactly one response per request, in order
// configuration: i_cfg_we writes i_cfg_wdata into the absorption gain (Q0.16);
// the user must write it only while no request is in flight, the block does not enforce this
// a request passes the input stage, the lane stages and the output stage to o_rsp.valid
// throughput: one request per cycle while o_rsp.ready stays high; every stage has its own
// valid bit so bubbles collapse and a stalled receiver only halts the stages
// that hold data
// reset: synchronous, active low; clears all valid bits and sets the gain to
// 65535 (one lsb below unity)
// stall: while o_rsp.ready is low the response holds; i_req.ready drops only
// once every stage behind it is full
module sdn_isotropic_scattering_junction_unit import sdn_isj_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [GAIN_W-1:0]     i_cfg_wdata,
    sdn_isj_in_if.sink            i_req,
    sdn_isj_out_if.source         o_rsp
);

    // input stage, lane stages, output stage
    localparam int STAGES = LANE_STAGES + 2;

    logic [GAIN_W-1:0]        r_gain;
    logic [STAGES-1:0]        r_vld;
    logic [STAGES-1:0]        n_vld;
    logic [STAGES-1:0]        w_adv;

    // input stage registers; r_src and r_sum are shared by all lanes, r_x holds one wave per lane
    t_sample                  r_src;
    t_sample                  r_x [NUM_PORTS];
    logic signed [SUM_W-1:0]  r_sum;

    t_sample                  w_x [NUM_PORTS];
    logic signed [SUM_W-1:0]  w_sum;
    t_lane_ctrl               w_lane_ctrl;
    t_sample                  w_wave [NUM_PORTS];
    t_sample                  w_out_wave [NUM_PORTS];
    logic signed [NODE_W-1:0] w_node;

    // absorption gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // per-stage flow control: a stage moves when it is empty or its successor moves
    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || o_rsp.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld = r_vld;
        if (w_adv[0]) begin
            n_vld[0] = i_req.valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_req.ready = w_adv[0];

    // gather the incoming waves and form S = s + sum(x)
    always_comb begin
        w_x[0] = i_req.wave_in_0;
        w_x[1] = i_req.wave_in_1;
        w_x[2] = i_req.wave_in_2;
        w_x[3] = i_req.wave_in_3;
        w_x[4] = i_req.wave_in_4;
        w_sum  = SUM_W'(i_req.source_sample);
        for (int k = 0; k < NUM_PORTS; k++) begin
            w_sum = w_sum + SUM_W'(w_x[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_src <= i_req.source_sample;
            r_x   <= w_x;
            r_sum <= w_sum;
        end
    end

    // one lane per connection, all stepping together
    assign w_lane_ctrl.en = w_adv[LANE_STAGES:1];

    for (genvar g = 0; g < NUM_PORTS; g++) begin : g_lane
        sdn_isj_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_lane_ctrl),
            .i_gain (r_gain),
            .i_src  (r_src),
            .i_sum  (r_sum),
            .i_x    (r_x[g]),
            .o_wave (w_wave[g])
        );
    end

    // node output sum and the response register
    sdn_isj_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_adv[STAGES-1]),
        .i_wave (w_wave),
        .o_wave (w_out_wave),
        .o_node (w_node)
    );

    assign o_rsp.valid       = r_vld[STAGES-1];
    assign o_rsp.wave_out_0  = w_out_wave[0];
    assign o_rsp.wave_out_1  = w_out_wave[1];
    assign o_rsp.wave_out_2  = w_out_wave[2];
    assign o_rsp.wave_out_3  = w_out_wave[3];
    assign o_rsp.wave_out_4  = w_out_wave[4];
    assign o_rsp.node_output = w_node;

endmodule

// ----- test/sdn_isj_scatter_checker.sv -----
`timescale 1ns / 1ps

module sdn_isj_scatter_checker import sdn_isj_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GAIN_W-1:0] i_cfg_wdata,
    sdn_isj_in_if             i_req,
    sdn_isj_out_if            i_rsp,
    output int                o_fail_count,
    output int                o_pending_count,
    output int                o_checked_count
);

    localparam longint WAVE_MAX   = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint WAVE_MIN   = -(longint'(1) << (SAMPLE_W - 1));
    localparam longint NODE_MAX   = (longint'(1) << (NODE_W - 1)) - 1;
    localparam longint NODE_MIN   = -(longint'(1) << (NODE_W - 1));

    typedef struct packed {
        logic signed [NODE_W-1:0]  node;
        t_sample [NUM_PORTS-1:0]   wave;
    } t_scatter_frame;

    t_scatter_frame              expected_frames[$];
    t_scatter_frame              want;
    t_scatter_frame              got;
    t_sample [NUM_PORTS-1:0]     waves_in;
    logic [GAIN_W-1:0]           wall_gain;
    int                          fail_total;
    int                          checked_total;

    // exact junction: g*(2*S - N*x_i - s)/(N*2^16), rounded once, ties up
    function automatic t_scatter_frame scatter_frame(
        input t_sample                 src,
        input t_sample [NUM_PORTS-1:0] wave,
        input logic [GAIN_W-1:0]       gain
    );
        t_scatter_frame f;
        longint total;
        longint num;
        longint dividend;
        longint divisor;
        longint q;
        longint node_sum;
        total    = src;
        divisor  = longint'(2 * NUM_PORTS) << FRAC_W;
        node_sum = 0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            total += wave[i];
        end
        for (int i = 0; i < NUM_PORTS; i++) begin
            num      = 2 * total - NUM_PORTS * longint'(wave[i]) - src;
            dividend = 2 * num * longint'(gain) + (divisor >>> 1);
            if (dividend >= 0) begin
                q = dividend / divisor;
            end else begin
                q = -((-dividend + divisor - 1) / divisor);
            end
            if (q > WAVE_MAX) q = WAVE_MAX;
            if (q < WAVE_MIN) q = WAVE_MIN;
            f.wave[i] = q[SAMPLE_W-1:0];
            node_sum += q;
        end
        if (node_sum > NODE_MAX) node_sum = NODE_MAX;
        if (node_sum < NODE_MIN) node_sum = NODE_MIN;
        f.node = node_sum[NODE_W-1:0];
        return f;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wall_gain = GAIN_RESET;
            expected_frames.delete();
        end else begin
            if (i_cfg_we) wall_gain = i_cfg_wdata;
            // retire the oldest expectation before queuing a new one
            if (i_rsp.valid && i_rsp.ready) begin
                got.wave = {i_rsp.wave_out_4, i_rsp.wave_out_3, i_rsp.wave_out_2,
                            i_rsp.wave_out_1, i_rsp.wave_out_0};
                got.node = i_rsp.node_output;
                if (expected_frames.size() == 0) begin
                    $display("%0t: response with no request waiting, node_output %0d",
                             $time, got.node);
                    fail_total++;
                end else begin
                    want = expected_frames.pop_front();
                    checked_total++;
                    for (int i = 0; i < NUM_PORTS; i++) begin
                        if (got.wave[i] !== want.wave[i]) begin
                            $display("%0t: wave_out_%0d mismatch, expected %0d, actual %0d",
                                     $time, i, want.wave[i], got.wave[i]);
                            fail_total++;
                        end
                    end
                    if (got.node !== want.node) begin
                        $display("%0t: node_output mismatch, expected %0d, actual %0d",
                                 $time, want.node, got.node);
                        fail_total++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                waves_in = {i_req.wave_in_4, i_req.wave_in_3, i_req.wave_in_2,
                            i_req.wave_in_1, i_req.wave_in_0};
                expected_frames.push_back(scatter_frame(i_req.source_sample, waves_in,
                                                        wall_gain));
            end
        end
        o_fail_count    <= fail_total;
        o_pending_count <= expected_frames.size();
        o_checked_count <= checked_total;
    end

endmodule

// ----- test/sdn_isotropic_scattering_junction_unit_tb.sv -----
`timescale 1ns / 1ps

module sdn_isotropic_scattering_junction_unit_tb;
    import sdn_isj_pkg::*;

    // run shape
    localparam int     PHASES       = 10;
    localparam int     PHASE_ITEMS  = 125;
    localparam int     PRESSURE_PH  = 3;     // phase with the long receiver hold-off
    localparam int     QUIET_PH     = 2;     // phase with no idling at all
    localparam int     LONG_HOLD    = 200;   // cycles the receiver holds off
    localparam int     DRAIN_CYCLES = 12;    // extra wait once the checker has nothing pending
    localparam t_sample MAX_S       = 16'sh7FFF;
    localparam t_sample MIN_S       = 16'sh8000;
    localparam t_sample ZERO_S      = 16'sh0000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [GAIN_W-1:0] cfg_wdata;

    sdn_isj_in_if  req_if ();
    sdn_isj_out_if rsp_if ();

    int fail_count;
    int pending_count;
    int checked_count;
    int request_count;
    int gain_writes;

    // idle controls shared between the stimulus and the receiver
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_off_pending;

    sdn_isotropic_scattering_junction_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // passive: watches both channels and the gain writes
    sdn_isj_scatter_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_req           (req_if),
        .i_rsp           (rsp_if),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // offer one request and hold it until the block takes it
    // called at a rising edge; may leave valid low for an idle burst afterwards
    task automatic send_request(input t_sample src, input t_sample [NUM_PORTS-1:0] w);
        req_if.valid         <= 1'b1;
        req_if.source_sample <= src;
        req_if.wave_in_0     <= w[0];
        req_if.wave_in_1     <= w[1];
        req_if.wave_in_2     <= w[2];
        req_if.wave_in_3     <= w[3];
        req_if.wave_in_4     <= w[4];
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        request_count++;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // gain writes only happen with the pipeline empty
    task automatic write_gain(input logic [GAIN_W-1:0] gain);
        cfg_we    <= 1'b1;
        cfg_wdata <= gain;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        gain_writes++;
    endtask

    // counts from the checker are registered, so wait for a clock edge before looking
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mix of full-range, corner and small values
    function automatic t_sample pick_sample();
        int unsigned kind;
        t_sample     v;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       v = MAX_S;
            1:       v = MIN_S;
            2:       v = t_sample'($urandom_range(0, 2)) - 16'sd1;
            3, 4:    v = t_sample'($urandom_range(0, 1023)) - 16'sd512;
            5:       v = t_sample'($urandom_range(0, 4095)) + 16'sh7000;
            default: v = t_sample'($urandom);
        endcase
        return v;
    endfunction

    // receiver: random back-pressure bursts, plus one long hold-off on request
    initial begin
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_off_pending = 1'b0;
                rsp_if.ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_sample [NUM_PORTS-1:0] w;
        logic [GAIN_W-1:0]       phase_gain;

        // every input known from time zero
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_if.valid         <= 1'b0;
        req_if.source_sample <= '0;
        req_if.wave_in_0     <= '0;
        req_if.wave_in_1     <= '0;
        req_if.wave_in_2     <= '0;
        req_if.wave_in_3     <= '0;
        req_if.wave_in_4     <= '0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        hold_off_pending = 1'b0;
        request_count    = 0;
        gain_writes      = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners with the reset gain, one lsb below unity
        send_request(ZERO_S, {5{ZERO_S}});
        send_request(MAX_S,  {5{MAX_S}});
        send_request(MIN_S,  {5{MIN_S}});
        send_request(MAX_S,  {5{ZERO_S}});
        send_request(MIN_S,  {5{ZERO_S}});
        // one port against all others: drives that port's output into saturation
        send_request(ZERO_S, {MAX_S, MAX_S, MAX_S, MAX_S, MIN_S});
        send_request(ZERO_S, {MIN_S, MIN_S, MIN_S, MIN_S, MAX_S});
        send_request(MAX_S,  {MIN_S, MAX_S, MAX_S, MAX_S, MAX_S});
        send_request(MIN_S,  {MAX_S, MIN_S, MIN_S, MIN_S, MIN_S});
        // single active connection, then all connections at alternating extremes
        send_request(ZERO_S, {ZERO_S, ZERO_S, MAX_S, ZERO_S, ZERO_S});
        send_request(ZERO_S, {MIN_S, ZERO_S, ZERO_S, ZERO_S, ZERO_S});
        send_request(ZERO_S, {MAX_S, MIN_S, MAX_S, MIN_S, MAX_S});
        // tiny values where rounding decides the result
        send_request(-16'sd1, {5{16'sd1}});
        send_request(16'sd1,  {5{-16'sd1}});
        send_request(16'sd3,  {16'sd0, 16'sd1, 16'sd2, -16'sd2, -16'sd1});
        req_if.valid <= 1'b0;
        wait_drained();

        // random phases, each under its own gain
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       phase_gain = '0;
                1:       phase_gain = 16'd1;
                2:       phase_gain = 16'h8000;
                3:       phase_gain = '1;
                4:       phase_gain = 16'hFFFE;
                PHASES - 1: phase_gain = '1;
                default: phase_gain = GAIN_W'($urandom);
            endcase
            write_gain(phase_gain);

            // idling per phase; none in the quiet phase and the final one, no sender idling under pressure
            tx_idle_on = (ph != QUIET_PH) && (ph != PHASES - 1) && (ph != PRESSURE_PH);
            rx_idle_on = (ph != QUIET_PH) && (ph != PHASES - 1);
            if (ph == PRESSURE_PH) hold_off_pending = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                for (int p = 0; p < NUM_PORTS; p++) w[p] = pick_sample();
                send_request(pick_sample(), w);
            end
            req_if.valid <= 1'b0;
            wait_drained();
        end

        $display("checked %0d responses against %0d requests over %0d gain writes",
                 checked_count, request_count, gain_writes);
        $display("corners, saturation, gain extremes, long output stall and idle bursts");
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/sdn_isj_pkg.sv
design/sdn_isj_if.sv
design/sdn_isj_lane.sv
design/sdn_isj_merge.sv
design/sdn_isotropic_scattering_junction_unit.sv
test/sdn_isj_scatter_checker.sv
test/sdn_isotropic_scattering_junction_unit_tb.sv
